@@ rtl/esdr_pkg.sv @@
// shared types and constants for the entity smoothing dead reckoning block
package esdr_pkg;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_SUB  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_ADD  = 7'b0010000,
    ST_CMP  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  // packet handling chosen by the first server item of a packet
  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_ACCEPT = 2'd1,
    MODE_LATE   = 2'd2
  } mode_e;

  // kind of work the sequencer runs on one entity
  typedef enum logic [1:0] {
    KIND_PRED = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_CHK  = 2'd2,
    KIND_LP   = 2'd3
  } kind_e;

  // configuration register index (byte address bits 3:2)
  typedef enum logic [1:0] {
    REG_SMOOTHING     = 2'd0,
    REG_FRAME_STEP    = 2'd1,
    REG_SNAP_DISTANCE = 2'd2
  } reg_e;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_SERVER  = 1'b1
  } cmd_e;

  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;

  localparam logic [15:0] SMOOTHING_RST     = 16'd52429;
  localparam logic [15:0] FRAME_STEP_RST    = 16'd1092;
  localparam logic [30:0] SNAP_DISTANCE_RST = 31'd2949120;

endpackage

@@ rtl/entity_smoothing_dead_reckoning.sv @@
// entity smoothing and dead reckoning: entity table, shared multiply/add unit and sequencer
//
// Keeps smoothed position and velocity per entity in a simple dual-port table (one row of four
// values per entity, registered read, a valid bit per row so the table reads as zero after
// reset with no clearing pass). Each transaction is worked by one shared datapath: a subtract
// step, a multiply by a Q0.16 weight, and a round/add/saturate step, stepped by a small
// one-hot sequencer, and the block takes no new item until the current one is finished.
// A predict item, or a server item of a late packet, runs two axes with two multiply passes
// each (subtract, multiply, add per pass). A low-passed server item runs two snap compares
// (subtract, compare), then four multiply passes. A snapped item stops at the compare that
// hits, a direct load goes from the table read straight to the result, and an item that
// changes nothing skips the table. A finished result sits in an output register,
// so the next item is taken while the previous result waits.
module entity_smoothing_dead_reckoning #(
  parameter int MAX_ENTITIES = 64,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [5:0]         entity_index_i,
  input  logic               first_of_packet_i,
  input  logic [31:0]        packet_tick_i,
  input  logic signed [31:0] server_pos_x_i,
  input  logic signed [31:0] server_pos_y_i,
  input  logic signed [31:0] server_vel_x_i,
  input  logic signed [31:0] server_vel_y_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         out_index_o,
  output logic               valid_res_o,
  output logic               was_late_o,
  output logic               snapped_o,
  output logic signed [31:0] filt_pos_x_o,
  output logic signed [31:0] filt_pos_y_o,
  output logic signed [31:0] filt_vel_x_o,
  output logic signed [31:0] filt_vel_y_o,
  // configuration port
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);

  localparam int VW    = VALUE_WIDTH;
  localparam int DW    = VW + 1;
  localparam int PW    = DW + 17;
  localparam int DEPTH = (MAX_ENTITIES < 64) ? MAX_ENTITIES : 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic signed [VW-1:0] sat_vw(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (VW - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[VW-1:0];
    end else if (v < lo) begin
      return lo[VW-1:0];
    end
    return v[VW-1:0];
  endfunction

  // configuration registers
  logic [15:0] smoothing_q;
  logic [15:0] frame_step_q;
  logic [30:0] snap_q;
  logic        cfg_we;

  // packet state
  logic                 loaded_q, loaded_d;
  esdr_pkg::mode_e      mode_q, mode_d;
  logic [31:0]          largest_tick_q, largest_tick_d;

  // sequencer
  esdr_pkg::state_e     state_q, state_d;
  esdr_pkg::kind_e      kind_q, kind_d;
  logic [1:0]           lane_q, lane_d;
  logic                 pass_q, pass_d;
  logic [5:0]           idx_q, idx_d;
  logic                 res_valid_q, res_valid_d;
  logic                 late_q, late_d;
  logic                 snap_hit_q, snap_hit_d;

  // shared unit and working values
  logic signed [DW-1:0] diff_q, diff_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [VW-1:0] tmp_q, tmp_d;
  logic signed [VW-1:0] val_q [4];
  logic signed [VW-1:0] val_d [4];
  logic signed [VW-1:0] srv_q [4];
  logic signed [VW-1:0] srv_d [4];

  // entity table
  logic [4*VW-1:0]      mem_q [DEPTH];
  logic [4*VW-1:0]      rd_row_q;
  logic [4*VW-1:0]      wr_row;
  logic                 mem_we;
  logic [DEPTH-1:0]     ent_valid_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [5:0]           out_index_q;
  logic                 out_vres_q, out_late_q, out_snap_q;
  logic signed [31:0]   out_val_q [4];
  logic                 out_load;

  // datapath helpers
  logic                 accept;
  logic                 is_first;
  logic                 in_range;
  esdr_pkg::mode_e      mode_new;
  logic                 loaded_new;
  logic signed [VW-1:0] sub_a, sub_b;
  logic [15:0]          mul_w;
  logic signed [PW-1:0] rnd_full;
  logic signed [VW-1:0] add_res;
  logic [DW-1:0]        mag;
  logic                 snap_cmp;
  logic                 pred_first;

  // ---------------------------------------------------------------------------
  // configuration port

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i & pready_o;

  always_comb begin
    case (esdr_pkg::reg_e'(paddr_i[3:2]))
      esdr_pkg::REG_SMOOTHING:     prdata_o = 32'(smoothing_q);
      esdr_pkg::REG_FRAME_STEP:    prdata_o = 32'(frame_step_q);
      esdr_pkg::REG_SNAP_DISTANCE: prdata_o = 32'(snap_q);
      default:                     prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothing_q  <= esdr_pkg::SMOOTHING_RST;
      frame_step_q <= esdr_pkg::FRAME_STEP_RST;
      snap_q       <= esdr_pkg::SNAP_DISTANCE_RST;
    end else if (cfg_we) begin
      case (esdr_pkg::reg_e'(paddr_i[3:2]))
        esdr_pkg::REG_SMOOTHING:     smoothing_q  <= pwdata_i[15:0];
        esdr_pkg::REG_FRAME_STEP:    frame_step_q <= pwdata_i[15:0];
        esdr_pkg::REG_SNAP_DISTANCE: snap_q       <= pwdata_i[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shared unit: subtract, multiply by weight, round/add/saturate, magnitude compare

  assign pred_first = (kind_q == esdr_pkg::KIND_PRED) && !pass_q;

  always_comb begin
    if (kind_q == esdr_pkg::KIND_PRED) begin
      sub_a = pass_q ? tmp_q : val_q[{1'b1, lane_q[0]}];
    end else begin
      sub_a = srv_q[lane_q];
    end
    sub_b = pred_first ? '0 : val_q[lane_q];
    mul_w = pred_first ? frame_step_q : smoothing_q;
  end

  assign rnd_full = (prod_q + PW'(esdr_pkg::ROUND_HALF)) >>> esdr_pkg::FRAC_BITS;
  assign add_res  = sat_vw(64'(val_q[lane_q]) + 64'($signed(rnd_full[DW-1:0])));
  assign mag      = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
  assign snap_cmp = 64'(mag) >= 64'(snap_q);

  // ---------------------------------------------------------------------------
  // packet decision at accept

  assign accept   = in_valid_i && !in_stall_o;
  assign is_first = (command_i == esdr_pkg::CMD_SERVER) && first_of_packet_i;
  assign in_range = 32'(entity_index_i) < MAX_ENTITIES;

  always_comb begin
    mode_new       = mode_q;
    loaded_new     = loaded_q;
    largest_tick_d = largest_tick_q;
    if (is_first) begin
      loaded_new = 1'b1;
      if (!loaded_q) begin
        mode_new       = esdr_pkg::MODE_DIRECT;
        largest_tick_d = packet_tick_i;
      end else if (packet_tick_i >= largest_tick_q) begin
        mode_new       = esdr_pkg::MODE_ACCEPT;
        largest_tick_d = packet_tick_i;
      end else begin
        mode_new = esdr_pkg::MODE_LATE;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer

  assign in_stall_o = (state_q != esdr_pkg::ST_IDLE);
  assign out_load   = (state_q == esdr_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  assign mem_we     = out_load && res_valid_q;
  assign wr_row     = {val_q[3], val_q[2], val_q[1], val_q[0]};

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    lane_d      = lane_q;
    pass_d      = pass_q;
    idx_d       = idx_q;
    res_valid_d = res_valid_q;
    late_d      = late_q;
    snap_hit_d  = snap_hit_q;
    loaded_d    = loaded_q;
    mode_d      = mode_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    tmp_d       = tmp_q;
    val_d       = val_q;
    srv_d       = srv_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      esdr_pkg::ST_IDLE: begin
        if (accept) begin
          loaded_d    = loaded_new;
          mode_d      = mode_new;
          idx_d       = entity_index_i;
          res_valid_d = loaded_new && in_range;
          late_d      = 1'b0;
          snap_hit_d  = 1'b0;
          lane_d      = 2'd0;
          pass_d      = 1'b0;
          srv_d[0]    = sat_vw(64'(server_pos_x_i));
          srv_d[1]    = sat_vw(64'(server_pos_y_i));
          srv_d[2]    = sat_vw(64'(server_vel_x_i));
          srv_d[3]    = sat_vw(64'(server_vel_y_i));
          if (command_i == esdr_pkg::CMD_PREDICT) begin
            kind_d = esdr_pkg::KIND_PRED;
          end else begin
            case (mode_new)
              esdr_pkg::MODE_DIRECT: kind_d = esdr_pkg::KIND_LOAD;
              esdr_pkg::MODE_ACCEPT: kind_d = esdr_pkg::KIND_CHK;
              default: begin
                kind_d = esdr_pkg::KIND_PRED;
                late_d = loaded_new && in_range;
              end
            endcase
          end
          state_d = (loaded_new && in_range) ? esdr_pkg::ST_READ : esdr_pkg::ST_DONE;
        end
      end

      esdr_pkg::ST_READ: begin
        if (kind_q == esdr_pkg::KIND_LOAD) begin
          val_d   = srv_q;
          state_d = esdr_pkg::ST_DONE;
        end else begin
          for (int k = 0; k < 4; k++) begin
            val_d[k] = ent_valid_q[idx_q[AW-1:0]] ? rd_row_q[k*VW +: VW] : '0;
          end
          state_d = esdr_pkg::ST_SUB;
        end
      end

      esdr_pkg::ST_SUB: begin
        diff_d  = DW'(sub_a) - DW'(sub_b);
        state_d = (kind_q == esdr_pkg::KIND_CHK) ? esdr_pkg::ST_CMP : esdr_pkg::ST_MUL;
      end

      esdr_pkg::ST_MUL: begin
        prod_d  = PW'(diff_q) * PW'($signed({1'b0, mul_w}));
        state_d = esdr_pkg::ST_ADD;
      end

      esdr_pkg::ST_ADD: begin
        state_d = esdr_pkg::ST_SUB;
        if (pred_first) begin
          // raw dead-reckoned position, filtered on the second pass
          tmp_d  = add_res;
          pass_d = 1'b1;
        end else begin
          val_d[lane_q] = add_res;
          pass_d        = 1'b0;
          if ((kind_q == esdr_pkg::KIND_PRED && lane_q == 2'd1) || lane_q == 2'd3) begin
            state_d = esdr_pkg::ST_DONE;
          end else begin
            lane_d = lane_q + 2'd1;
          end
        end
      end

      esdr_pkg::ST_CMP: begin
        if (snap_cmp) begin
          snap_hit_d = 1'b1;
          val_d      = srv_q;
          state_d    = esdr_pkg::ST_DONE;
        end else if (lane_q == 2'd1) begin
          kind_d  = esdr_pkg::KIND_LP;
          lane_d  = 2'd0;
          state_d = esdr_pkg::ST_SUB;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = esdr_pkg::ST_SUB;
        end
      end

      esdr_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = esdr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = esdr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= esdr_pkg::ST_IDLE;
      kind_q         <= esdr_pkg::KIND_PRED;
      lane_q         <= '0;
      pass_q         <= 1'b0;
      idx_q          <= '0;
      res_valid_q    <= 1'b0;
      late_q         <= 1'b0;
      snap_hit_q     <= 1'b0;
      loaded_q       <= 1'b0;
      mode_q         <= esdr_pkg::MODE_DIRECT;
      largest_tick_q <= '0;
      out_valid_q    <= 1'b0;
      ent_valid_q    <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      lane_q      <= lane_d;
      pass_q      <= pass_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
      late_q      <= late_d;
      snap_hit_q  <= snap_hit_d;
      loaded_q    <= loaded_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        largest_tick_q <= largest_tick_d;
      end
      if (mem_we) begin
        ent_valid_q[idx_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    prod_q <= prod_d;
    tmp_q  <= tmp_d;
    val_q  <= val_d;
    srv_q  <= srv_d;
    if (out_load) begin
      out_index_q <= idx_q;
      out_vres_q  <= res_valid_q;
      out_late_q  <= late_q;
      out_snap_q  <= snap_hit_q;
      for (int k = 0; k < 4; k++) begin
        out_val_q[k] <= res_valid_q ? 32'(val_q[k]) : '0;
      end
    end
  end

  // entity table, one row per entity
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q[AW-1:0]] <= wr_row;
    end
    rd_row_q <= mem_q[entity_index_i[AW-1:0]];
  end

  // ---------------------------------------------------------------------------
  // outputs

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign valid_res_o  = out_vres_q;
  assign was_late_o   = out_late_q;
  assign snapped_o    = out_snap_q;
  assign filt_pos_x_o = out_val_q[0];
  assign filt_pos_y_o = out_val_q[1];
  assign filt_vel_x_o = out_val_q[2];
  assign filt_vel_y_o = out_val_q[3];

  // ---------------------------------------------------------------------------
  // assertions

  a_no_result_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      (!was_late_o && !snapped_o && filt_pos_x_o == '0 && filt_vel_y_o == '0))
    else $error("result without table write carries flags or values");

  a_late_snap_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(was_late_o && snapped_o))
    else $error("late and snapped reported together");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_first && loaded_q && packet_tick_i >= largest_tick_q) |=>
      (largest_tick_q == $past(packet_tick_i)))
    else $error("accepted packet did not advance largest tick");

  a_write_needs_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (loaded_q && res_valid_q))
    else $error("table written before any packet was loaded");

endmodule

@@ verif/entity_smoothing_dead_reckoning_test.sv @@
// testbench for entity_smoothing_dead_reckoning: directed and random transactions against a tracker
module entity_smoothing_dead_reckoning_test;
  import esdr_pkg::*;

  localparam int     CYCLE_LIMIT = 500000;
  localparam int     MAX_PRINTS  = 30;
  localparam int     PHASES      = 6;
  localparam int     PHASE_ITEMS = 175;
  localparam longint Q_MAX       = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN       = -Q_MAX - 1;

  typedef struct {
    cmd_e               cmd;
    logic [5:0]         idx;
    logic               first;
    logic [31:0]        tick;
    logic signed [31:0] px, py, vx, vy;
  } entity_item_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic        valid;
    logic        late;
    logic        snap;
    logic [31:0] px, py, vx, vy;
  } entity_report_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [5:0]         entity_index_i;
  logic               first_of_packet_i;
  logic [31:0]        packet_tick_i;
  logic signed [31:0] server_pos_x_i, server_pos_y_i, server_vel_x_i, server_vel_y_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [5:0]         out_index_o;
  logic               valid_res_o, was_late_o, snapped_o;
  logic signed [31:0] filt_pos_x_o, filt_pos_y_o, filt_vel_x_o, filt_vel_y_o;
  logic               psel_i, penable_i, pwrite_i;
  logic [3:0]         paddr_i;
  logic [31:0]        pwdata_i;
  logic [31:0]        prdata_o;
  logic               pready_o;

  // tracker copy of the entity table, packet state and registers
  longint      ent_tbl [64][4];
  logic [31:0] largest_tick;
  logic        table_loaded;
  mode_e       packet_mode;
  logic [15:0] cfg_smoothing;
  logic [15:0] cfg_frame_step;
  logic [30:0] cfg_snap;

  entity_report_t reports_q[$];

  int cycle_count     = 0;
  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int n_direct = 0, n_blend = 0, n_snap = 0, n_late = 0, n_advance = 0, n_unloaded = 0;

  entity_smoothing_dead_reckoning i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .entity_index_i    (entity_index_i),
    .first_of_packet_i (first_of_packet_i),
    .packet_tick_i     (packet_tick_i),
    .server_pos_x_i    (server_pos_x_i),
    .server_pos_y_i    (server_pos_y_i),
    .server_vel_x_i    (server_vel_x_i),
    .server_vel_y_i    (server_vel_y_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_index_o       (out_index_o),
    .valid_res_o       (valid_res_o),
    .was_late_o        (was_late_o),
    .snapped_o         (snapped_o),
    .filt_pos_x_o      (filt_pos_x_o),
    .filt_pos_y_o      (filt_pos_y_o),
    .filt_vel_x_o      (filt_vel_x_o),
    .filt_vel_y_o      (filt_vel_y_o),
    .psel_i            (psel_i),
    .penable_i         (penable_i),
    .pwrite_i          (pwrite_i),
    .paddr_i           (paddr_i),
    .pwdata_i          (pwdata_i),
    .prdata_o          (prdata_o),
    .pready_o          (pready_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, reports_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- tracker

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // rounds to nearest, halves up; arithmetic shift gives the floor
  function automatic longint weight_mul(longint a, logic [15:0] w);
    longint wl;
    wl = w;
    return (a * wl + ROUND_HALF) >>> FRAC_BITS;
  endfunction

  function automatic entity_report_t track_item(entity_item_t it);
    entity_report_t r;
    longint         srv [4];
    longint         raw;
    longint         d;
    logic           far;
    r = '0;
    r.idx = it.idx;
    srv[0] = it.px;
    srv[1] = it.py;
    srv[2] = it.vx;
    srv[3] = it.vy;
    if (it.cmd == CMD_SERVER && it.first) begin
      if (!table_loaded) begin
        table_loaded = 1'b1;
        packet_mode = MODE_DIRECT;
        largest_tick = it.tick;
      end else if (it.tick >= largest_tick) begin
        largest_tick = it.tick;
        packet_mode = MODE_ACCEPT;
      end else begin
        packet_mode = MODE_LATE;
      end
    end
    if (!table_loaded) begin
      n_unloaded++;
      return r;
    end
    r.valid = 1'b1;
    if (it.cmd == CMD_PREDICT || packet_mode == MODE_LATE) begin
      r.late = (it.cmd == CMD_SERVER);
      if (r.late) n_late++;
      else n_advance++;
      for (int k = 0; k < 2; k++) begin
        raw = clamp_q(ent_tbl[it.idx][k] + weight_mul(ent_tbl[it.idx][k+2], cfg_frame_step));
        ent_tbl[it.idx][k] = clamp_q(ent_tbl[it.idx][k] +
                                     weight_mul(raw - ent_tbl[it.idx][k], cfg_smoothing));
      end
    end else begin
      far = 1'b0;
      for (int k = 0; k < 2; k++) begin
        d = srv[k] - ent_tbl[it.idx][k];
        if (d < 0) d = -d;
        if (d >= longint'(cfg_snap)) far = 1'b1;
      end
      if (packet_mode == MODE_DIRECT || far) begin
        r.snap = (packet_mode == MODE_ACCEPT);
        if (r.snap) n_snap++;
        else n_direct++;
        for (int k = 0; k < 4; k++) ent_tbl[it.idx][k] = srv[k];
      end else begin
        n_blend++;
        for (int k = 0; k < 4; k++)
          ent_tbl[it.idx][k] = clamp_q(ent_tbl[it.idx][k] +
                                       weight_mul(srv[k] - ent_tbl[it.idx][k], cfg_smoothing));
      end
    end
    r.px = ent_tbl[it.idx][0][31:0];
    r.py = ent_tbl[it.idx][1][31:0];
    r.vx = ent_tbl[it.idx][2][31:0];
    r.vy = ent_tbl[it.idx][3][31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what);
    if (errors < MAX_PRINTS) $display("[cycle %0d] mismatch: %s", cycle_count, what);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    entity_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reports_q.size() == 0) begin
        report_mismatch("result transaction with nothing pending");
      end else begin
        want = reports_q.pop_front();
        check_field("out_index", out_index_o, want.idx);
        check_field("valid_res", valid_res_o, want.valid);
        check_field("was_late", was_late_o, want.late);
        check_field("snapped", snapped_o, want.snap);
        check_field("filt_pos_x", filt_pos_x_o, want.px);
        check_field("filt_pos_y", filt_pos_y_o, want.py);
        check_field("filt_vel_x", filt_vel_x_o, want.vx);
        check_field("filt_vel_y", filt_vel_y_o, want.vy);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic entity_item_t make_item(cmd_e c, logic [5:0] idx, logic first,
                                             logic [31:0] tick, longint px, longint py,
                                             longint vx, longint vy);
    entity_item_t it;
    it.cmd = c;
    it.idx = idx;
    it.first = first;
    it.tick = tick;
    it.px = px[31:0];
    it.py = py[31:0];
    it.vx = vx[31:0];
    it.vy = vy[31:0];
    return it;
  endfunction

  task automatic send_item(entity_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    command_i <= it.cmd;
    entity_index_i <= it.idx;
    first_of_packet_i <= it.first;
    packet_tick_i <= it.tick;
    server_pos_x_i <= it.px;
    server_pos_y_i <= it.py;
    server_vel_x_i <= it.vx;
    server_vel_y_i <= it.vy;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    reports_q.push_back(track_item(it));
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (reports_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_cycle(logic wr, reg_e r, logic [31:0] wdata, output logic [31:0] rdata);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= wr;
    paddr_i <= {r, 2'b00};
    pwdata_i <= wdata;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rdata = prdata_o;
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [31:0] value);
    logic [31:0] rd;
    apb_cycle(1'b1, r, value, rd);
    reg_writes++;
    apb_cycle(1'b0, r, 32'd0, rd);
    check_field($sformatf("readback of %s", r.name()), rd, value);
  endtask

  // only called with the block idle
  task automatic set_config(logic [15:0] sm, logic [15:0] fs, logic [30:0] sd);
    drain();
    write_reg(REG_SMOOTHING, {16'd0, sm});
    write_reg(REG_FRAME_STEP, {16'd0, fs});
    write_reg(REG_SNAP_DISTANCE, {1'b0, sd});
    cfg_smoothing = sm;
    cfg_frame_step = fs;
    cfg_snap = sd;
  endtask

  function automatic longint near_value(longint cur, longint span);
    longint off;
    off = longint'($urandom_range(0, 32'(2 * span))) - span;
    return clamp_q(cur + off);
  endfunction

  task automatic send_junk_predict();
    send_item(make_item(CMD_PREDICT, 6'($urandom), 1'($urandom), $urandom,
                        int'($urandom), int'($urandom), int'($urandom), int'($urandom)));
  endtask

  task automatic send_noise_item();
    send_item(make_item(cmd_e'($urandom_range(1)), 6'($urandom), 1'($urandom), $urandom,
                        int'($urandom), int'($urandom), int'($urandom), int'($urandom)));
  endtask

  // one packet of server data, mostly close to the tracked values so the filter path is reached
  task automatic send_server_packet();
    logic [31:0] tick;
    longint      gap;
    longint      span;
    longint      val [4];
    logic [5:0]  idx;
    int          n;
    if ($urandom_range(99) < 20 && largest_tick != 0) begin
      gap = $urandom_range(1, 1000);
      if (gap > largest_tick) gap = largest_tick;
      tick = largest_tick - gap[31:0];
    end else begin
      tick = largest_tick + $urandom_range(0, 3);
      if (tick < largest_tick) tick = largest_tick;
    end
    n = $urandom_range(1, 6);
    for (int j = 0; j < n; j++) begin
      if (j > 0 && $urandom_range(99) < 25) send_junk_predict();
      idx = 6'($urandom);
      span = (cfg_snap > 0) ? cfg_snap - 1 : 0;
      if (span > (1 << 22)) span = 1 << 22;
      for (int k = 0; k < 2; k++)
        val[k] = ($urandom_range(99) < 10) ? longint'(int'($urandom))
                                           : near_value(ent_tbl[idx][k], span);
      for (int k = 2; k < 4; k++)
        val[k] = ($urandom_range(99) < 80) ? near_value(ent_tbl[idx][k], 1 << 20)
                                           : longint'(int'($urandom));
      send_item(make_item(CMD_SERVER, idx, j == 0, tick, val[0], val[1], val[2], val[3]));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_unloaded();
    send_item(make_item(CMD_PREDICT, 6'd0, 1'b0, 32'hFFFF_FFFF, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    send_item(make_item(CMD_SERVER, 6'd63, 1'b0, 32'hFFFF_FFFF, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    send_item(make_item(CMD_PREDICT, 6'd1, 1'b1, 32'd0, -1, -1, -1, -1));
  endtask

  task automatic test_direct_load();
    send_item(make_item(CMD_SERVER, 6'd0, 1'b1, 32'd0, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    // direct load holds for the rest of the packet
    send_item(make_item(CMD_SERVER, 6'd63, 1'b0, 32'd0, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    send_item(make_item(CMD_SERVER, 6'd5, 1'b0, 32'd0, 1 << 16, -(3 << 16), 10 << 16,
                        -(20 << 16)));
    send_item(make_item(CMD_PREDICT, 6'd0, 1'b0, 32'd0, 0, 0, 0, 0));
    send_item(make_item(CMD_PREDICT, 6'd63, 1'b0, 32'd0, 0, 0, 0, 0));
    send_item(make_item(CMD_PREDICT, 6'd5, 1'b0, 32'd0, 0, 0, 0, 0));
  endtask

  task automatic test_filter_paths();
    // equal tick is accepted
    send_item(make_item(CMD_SERVER, 6'd5, 1'b1, 32'd0, ent_tbl[5][0] + 65536,
                        ent_tbl[5][1] - 65536, ent_tbl[5][2] + 1000, ent_tbl[5][3] - 1000));
    // just under the snap distance, then exactly on it
    send_item(make_item(CMD_SERVER, 6'd5, 1'b0, 32'd0, ent_tbl[5][0] + longint'(cfg_snap) - 1,
                        ent_tbl[5][1], ent_tbl[5][2], ent_tbl[5][3]));
    send_item(make_item(CMD_SERVER, 6'd5, 1'b0, 32'd0, ent_tbl[5][0],
                        ent_tbl[5][1] - longint'(cfg_snap), -(7 << 16), 7 << 16));
    send_item(make_item(CMD_SERVER, 6'd5, 1'b0, 32'd0, ent_tbl[5][0] + (100 << 16),
                        ent_tbl[5][1], 2 << 16, -(2 << 16)));
  endtask

  task automatic test_late_packets();
    send_item(make_item(CMD_SERVER, 6'd7, 1'b1, 32'd100, 3 << 16, 4 << 16, 30 << 16,
                        -(40 << 16)));
    send_item(make_item(CMD_SERVER, 6'd7, 1'b1, 32'd99, 0, 0, 0, 0));
    // late mode sticks even when a later item carries a newer tick
    send_item(make_item(CMD_SERVER, 6'd8, 1'b0, 32'd200, 1 << 16, 1 << 16, 0, 0));
    send_item(make_item(CMD_SERVER, 6'd7, 1'b1, 32'd100, ent_tbl[7][0] + 300,
                        ent_tbl[7][1] - 300, ent_tbl[7][2], ent_tbl[7][3]));
  endtask

  task automatic test_config_extremes();
    set_config(16'hFFFF, 16'hFFFF, SNAP_DISTANCE_RST);
    send_item(make_item(CMD_PREDICT, 6'd5, 1'b0, 32'd0, 0, 0, 0, 0));
    send_item(make_item(CMD_PREDICT, 6'd0, 1'b0, 32'd0, 0, 0, 0, 0));
    set_config(16'd0, 16'd0, SNAP_DISTANCE_RST);
    send_item(make_item(CMD_PREDICT, 6'd5, 1'b0, 32'd0, 0, 0, 0, 0));
    send_item(make_item(CMD_SERVER, 6'd5, 1'b1, 32'd100, ent_tbl[5][0] + 5, ent_tbl[5][1],
                        ent_tbl[5][2] + 9, ent_tbl[5][3]));
    set_config(SMOOTHING_RST, FRAME_STEP_RST, 31'd0);
    send_item(make_item(CMD_SERVER, 6'd5, 1'b0, 32'd100, ent_tbl[5][0], ent_tbl[5][1], 0, 0));
    // full-scale jump still reaches the largest threshold
    set_config(SMOOTHING_RST, FRAME_STEP_RST, 31'h7FFF_FFFF);
    send_item(make_item(CMD_SERVER, 6'd63, 1'b0, 32'd100, Q_MAX, Q_MIN, 0, 0));
  endtask

  task automatic test_random_phases();
    int  target;
    int  midpoint;
    int  pick;
    bit  paused;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(SMOOTHING_RST, FRAME_STEP_RST, SNAP_DISTANCE_RST);
        1: set_config(16'd0, 16'd0, 31'd0);
        2: set_config(16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF);
        4: set_config(16'hFFFF, 16'd0, 31'($urandom_range(1, 1 << 20)));
        default: set_config(16'($urandom), 16'($urandom), 31'($urandom_range(0, 60 << 16)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      target = items_sent + PHASE_ITEMS;
      midpoint = items_sent + PHASE_ITEMS / 2;
      paused = 1'b0;
      while (items_sent < target) begin
        // hold off until the pipeline is empty once per phase
        if (!paused && items_sent >= midpoint) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_server_packet();
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 4)) send_junk_predict();
        end else begin
          send_noise_item();
        end
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    for (int i = 0; i < 64; i++)
      for (int k = 0; k < 4; k++) ent_tbl[i][k] = 0;
    largest_tick = '0;
    table_loaded = 1'b0;
    packet_mode = MODE_DIRECT;
    cfg_smoothing = SMOOTHING_RST;
    cfg_frame_step = FRAME_STEP_RST;
    cfg_snap = SNAP_DISTANCE_RST;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    command_i <= CMD_PREDICT;
    entity_index_i <= '0;
    first_of_packet_i <= 1'b0;
    packet_tick_i <= '0;
    server_pos_x_i <= '0;
    server_pos_y_i <= '0;
    server_vel_x_i <= '0;
    server_vel_y_i <= '0;
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    paddr_i <= '0;
    pwdata_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unloaded();
    test_direct_load();
    test_filter_paths();
    test_late_packets();
    test_config_extremes();
    test_random_phases();

    drain();
    repeat (40) @(posedge clk_i);
    if (reports_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", reports_q.size()));
    $display("covered %0d transactions in, %0d results checked, %0d register writes",
             items_sent, results_checked, reg_writes);
    $display("paths: %0d direct, %0d filtered, %0d snapped, %0d late, %0d reckoned, %0d unloaded",
             n_direct, n_blend, n_snap, n_late, n_advance, n_unloaded);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
